### rtl/bba_pkg.sv
// Shared types, codes and defaults for the buddy block allocator.
package bba_pkg;

  localparam int DEF_LAYERS = 8;
  localparam int DEF_TREES  = 4;

  localparam logic [40:0] BLOCK_SIZE_RESET = 41'd1048576;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Node marks
  localparam logic [1:0] MARK_ABSENT = 2'd0;
  localparam logic [1:0] MARK_FREE   = 2'd1;
  localparam logic [1:0] MARK_USED   = 2'd2;
  localparam logic [1:0] MARK_SPLIT  = 2'd3;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [2:0] level;
    logic [1:0] tree_id;
    logic [6:0] node_index;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  tree_id;
    logic [6:0]  node_index;
    logic [39:0] byte_offset;
    logic        new_tree;
  } bba_res_t;

endpackage

### rtl/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: APB register, streams, output stage.
//
// Channel  Dir  Contents
// s_*      in   tuser: mode; tdata: level[2:0], tree_id[4:3], node_index[11:5]
// m_*      out  tuser: status[1:0], new_tree[2]; tdata: tree_id_out[1:0],
//               node_index_out[8:2], byte_offset[48:9]
// APB      in   block_size at address 0 (64-bit data)
//
// From input transaction to output transaction: an allocation searches, splits
// level by level and pops its node; a free pushes the node, then per merged
// level checks the sibling, removes both buddies and pushes the parent; a
// rejected or ignored request ends without touching the free lists. The steps
// follow the registered reads of the mark, free-list and slot memories. One
// item is worked at a time. After reset a clearing pass over every mark entry
// (1024 by default) marks all nodes absent; s_tready is low then.
// The output register lets the next item start while a result waits.
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int LAYERS = DEF_LAYERS,
  parameter int TREES  = DEF_TREES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // level, tree_id, node_index, zero pad
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // tree_id_out, node_index_out, byte_offset, pad
  output logic [2:0]  m_tuser,   // status, new_tree
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [40:0] block_size;
  bba_req_t    req;
  bba_res_t    res, out_r;
  logic        res_valid, res_take;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? 64'(block_size) : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
      block_size <= pwdata[40:0];
    end
  end

  assign req.mode       = s_tuser;
  assign req.level      = s_tdata[2:0];
  assign req.tree_id    = s_tdata[4:3];
  assign req.node_index = s_tdata[11:5];

  bba_engine #(.LAYERS(LAYERS), .TREES(TREES)) u_engine (
    .clk(clk), .rst(rst),
    .req_valid(s_tvalid), .req_ready(s_tready), .req(req),
    .block_size(block_size),
    .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  // Output register
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign m_tdata = {7'd0, out_r.byte_offset, out_r.node_index, out_r.tree_id};
  assign m_tuser = {out_r.new_tree, out_r.status};

endmodule

### rtl/bba_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module bba_ram #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/bba_engine.sv
// Allocation engine: sequencer over the mark, free-list and slot memories.
module bba_engine
  import bba_pkg::*;
#(
  parameter int LAYERS = DEF_LAYERS,
  parameter int TREES  = DEF_TREES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  bba_req_t    req,
  input  logic [40:0] block_size,
  output logic        res_valid,
  input  logic        res_take,
  output bba_res_t    res
);

  localparam int TW    = (TREES > 1) ? $clog2(TREES) : 1;
  localparam int LW    = LAYERS;
  localparam int NW    = TW + LW;
  localparam int VW    = $clog2(LAYERS);
  localparam int SLOTS = TREES << (LAYERS - 1);
  localparam int PW    = $clog2(SLOTS);
  localparam int CW    = PW + 1;
  localparam int OW    = $clog2(TREES + 1);
  localparam int IW    = LAYERS - 1;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_FCHK  = 5'd2;
  localparam logic [4:0] S_MRD   = 5'd3;
  localparam logic [4:0] S_MCHK  = 5'd4;
  localparam logic [4:0] S_R1    = 5'd5;
  localparam logic [4:0] S_R2    = 5'd6;
  localparam logic [4:0] S_R3    = 5'd7;
  localparam logic [4:0] S_R4    = 5'd8;
  localparam logic [4:0] S_ASRCH = 5'd9;
  localparam logic [4:0] S_S1    = 5'd10;
  localparam logic [4:0] S_S2    = 5'd11;
  localparam logic [4:0] S_S3    = 5'd12;
  localparam logic [4:0] S_S4    = 5'd13;
  localparam logic [4:0] S_P1    = 5'd14;
  localparam logic [4:0] S_P2    = 5'd15;
  localparam logic [4:0] S_P3    = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]    state, state_next;
  logic [NW-1:0] clr;
  logic [CW-1:0] cnt [LAYERS];
  logic [OW-1:0] opened;
  logic [VW-1:0] lv, slv;
  logic [TW-1:0] tree;
  logic [LW-1:0] loc;
  logic [NW-1:0] node;
  logic [IW-1:0] idx_r;
  bba_res_t      res_r;

  // Memory ports
  logic          nm_we, fs_we, sp_we;
  logic [NW-1:0] nm_waddr, nm_raddr, sp_waddr, sp_raddr;
  logic [1:0]    nm_wdata, nm_rdata;
  logic [VW+PW-1:0] fs_waddr, fs_raddr;
  logic [NW-1:0] fs_wdata, fs_rdata;
  logic [PW-1:0] sp_wdata, sp_rdata;

  bba_ram #(.AW(NW), .DW(2)) u_mark (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
    .raddr(nm_raddr), .rdata(nm_rdata)
  );
  bba_ram #(.AW(VW + PW), .DW(NW)) u_stack (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );
  bba_ram #(.AW(NW), .DW(PW)) u_slot (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(sp_raddr), .rdata(sp_rdata)
  );

  // Derived node addresses and counts
  logic [LW-1:0] sib_loc, par_loc, in_loc, pl_left, pl_right;
  logic [NW-1:0] cur_g, sib_g;
  logic [PW-1:0] last;
  logic [VW-1:0] in_lv;
  logic          in_range, in_bad_free;
  logic          found;
  logic [VW-1:0] src;

  assign in_lv     = VW'(req.level);
  assign in_range  = 32'(req.level) < LAYERS;
  assign in_loc    = LW'((LW'(1) << in_lv) - LW'(1)) + LW'(req.node_index);
  assign in_bad_free = (32'(req.tree_id) >= 32'(opened)) ||
                       (32'(req.node_index) >= (32'(1) << in_lv));
  assign sib_loc   = loc[0] ? (loc + LW'(1)) : (loc - LW'(1));
  assign par_loc   = (loc - LW'(1)) >> 1;
  assign cur_g     = {tree, loc};
  assign sib_g     = {tree, sib_loc};
  assign last      = PW'(cnt[lv] - CW'(1));
  assign pl_left   = LW'({node[LW-1:0], 1'b1});
  assign pl_right  = LW'({node[LW-1:0], 1'b0}) + LW'(2);

  // Nearest shallower non-empty level
  always_comb begin
    found = 1'b0;
    src   = '0;
    for (int k = 0; k < LAYERS; k++) begin
      if (k < 32'(lv) && cnt[k] != '0) begin
        found = 1'b1;
        src   = VW'(k);
      end
    end
  end

  // Push and count update requests
  logic          push_en;
  logic [VW-1:0] push_lv;
  logic [NW-1:0] push_g;
  logic          dec_en;
  logic [VW-1:0] dec_lv;
  logic [PW-1:0] rm_pos;
  logic [NW-1:0] rm_moved;
  logic [PW-1:0] slv_last;

  assign rm_pos   = sp_rdata;
  assign rm_moved = fs_rdata;
  assign slv_last = PW'(cnt[slv] - CW'(1));

  always_comb begin
    state_next = state;
    push_en  = 1'b0;
    push_lv  = lv;
    push_g   = cur_g;
    dec_en   = 1'b0;
    dec_lv   = lv;
    nm_we    = 1'b0;
    nm_waddr = cur_g;
    nm_wdata = MARK_ABSENT;
    nm_raddr = cur_g;
    fs_we    = 1'b0;
    fs_waddr = {lv, rm_pos};
    fs_wdata = rm_moved;
    fs_raddr = {lv, last};
    sp_we    = 1'b0;
    sp_waddr = rm_moved;
    sp_wdata = rm_pos;
    sp_raddr = cur_g;
    case (state)
      S_CLEAR: begin
        nm_we    = 1'b1;
        nm_waddr = clr;
        if (clr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        nm_raddr = {TW'(req.tree_id), in_loc};
        if (req_valid) begin
          if (!in_range) begin
            state_next = S_DONE;
          end else if (req.mode == MODE_FREE) begin
            state_next = in_bad_free ? S_DONE : S_FCHK;
          end else begin
            state_next = S_ASRCH;
          end
        end
      end
      S_FCHK: begin
        if (nm_rdata != MARK_USED) begin
          state_next = S_DONE;
        end else begin
          push_en    = 1'b1;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        nm_raddr = sib_g;
        state_next = (lv == '0) ? S_DONE : S_MCHK;
      end
      S_MCHK: begin
        sp_raddr = cur_g;
        state_next = (nm_rdata != MARK_FREE) ? S_DONE : S_R1;
      end
      S_R1, S_R3: begin
        // swap-with-last removal
        fs_we  = (rm_pos != last);
        sp_we  = (rm_pos != last);
        dec_en = 1'b1;
        nm_we  = 1'b1;
        nm_waddr = (state == S_R1) ? cur_g : sib_g;
        state_next = (state == S_R1) ? S_R2 : S_R4;
      end
      S_R2: begin
        sp_raddr   = sib_g;
        state_next = S_R3;
      end
      S_R4: begin
        push_en    = 1'b1;
        push_lv    = lv - VW'(1);
        push_g     = {tree, par_loc};
        state_next = S_MRD;
      end
      S_ASRCH: begin
        if (cnt[lv] != '0) begin
          state_next = S_P1;
        end else if (found) begin
          state_next = S_S1;
        end else if (32'(opened) >= TREES) begin
          state_next = S_DONE;
        end else begin
          push_en    = 1'b1;
          push_lv    = '0;
          push_g     = {TW'(opened), LW'(0)};
          state_next = (lv == '0) ? S_P1 : S_S1;
        end
      end
      S_S1: begin
        fs_raddr   = {slv, slv_last};
        dec_en     = 1'b1;
        dec_lv     = slv;
        state_next = S_S2;
      end
      S_S2: begin
        nm_we      = 1'b1;
        nm_waddr   = fs_rdata;
        nm_wdata   = MARK_SPLIT;
        state_next = S_S3;
      end
      S_S3: begin
        push_en    = 1'b1;
        push_lv    = slv + VW'(1);
        push_g     = {node[NW-1:LW], pl_left};
        state_next = S_S4;
      end
      S_S4: begin
        push_en    = 1'b1;
        push_lv    = slv + VW'(1);
        push_g     = {node[NW-1:LW], pl_right};
        state_next = (slv + VW'(1) == lv) ? S_P1 : S_S1;
      end
      S_P1: begin
        dec_en     = 1'b1;
        state_next = S_P2;
      end
      S_P2: begin
        nm_we      = 1'b1;
        nm_waddr   = fs_rdata;
        nm_wdata   = MARK_USED;
        state_next = S_P3;
      end
      S_P3: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a push writes all three memories at once
    if (push_en) begin
      fs_we    = 1'b1;
      fs_waddr = {push_lv, cnt[push_lv][PW-1:0]};
      fs_wdata = push_g;
      sp_we    = 1'b1;
      sp_waddr = push_g;
      sp_wdata = cnt[push_lv][PW-1:0];
      nm_we    = 1'b1;
      nm_waddr = push_g;
      nm_wdata = MARK_FREE;
    end
  end

  // Offset product, one multiplier
  logic [IW+40:0] prod;
  assign prod = (IW+41)'(idx_r) * (IW+41)'(block_size >> lv);

  // Control and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      opened <= '0;
      for (int k = 0; k < LAYERS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + NW'(1);
      end
      if (push_en) begin
        cnt[push_lv] <= cnt[push_lv] + CW'(1);
      end else if (dec_en) begin
        cnt[dec_lv] <= cnt[dec_lv] - CW'(1);
      end
      if (state == S_ASRCH && state_next != S_DONE && push_en) begin
        opened <= opened + OW'(1);
      end
    end
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lv        <= in_lv;
        tree      <= TW'(req.tree_id);
        loc       <= in_loc;
        res_r     <= bba_res_t'({(in_range ? ST_OK : ST_RANGE), 50'd0});
      end
      S_R4: begin
        lv  <= lv - VW'(1);
        loc <= par_loc;
      end
      S_ASRCH: begin
        slv <= found ? src : '0;
        if (cnt[lv] == '0 && !found) begin
          if (32'(opened) >= TREES) begin
            res_r.status <= ST_NO_TREE;
          end else begin
            res_r.new_tree <= 1'b1;
          end
        end
      end
      S_S2: begin
        node <= fs_rdata;
      end
      S_S4: begin
        slv <= slv + VW'(1);
      end
      S_P2: begin
        res_r.tree_id <= 2'(fs_rdata[NW-1:LW]);
        idx_r <= IW'(fs_rdata[LW-1:0] - LW'((LW'(1) << lv) - LW'(1)));
      end
      S_P3: begin
        res_r.node_index  <= 7'(idx_r);
        res_r.byte_offset <= prod[39:0];
      end
      default: begin
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_r;

  // Checks
  a_opened_cap: assert property (@(posedge clk) disable iff (rst)
    32'(opened) <= TREES) else $error("more trees opened than exist");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_en |-> 32'(cnt[push_lv]) < SLOTS) else $error("free list overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (dec_en && !push_en) |-> cnt[dec_lv] != '0) else $error("pop from empty list");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_take) |=> (state == S_DONE && $stable(res)))
    else $error("result dropped before transfer");

endmodule
